// ===== rtl/core/tbqd_pkg.sv =====
// Shared types and codes of the turn-based queue dispatcher.
`timescale 1ns / 1ps

package tbqd_pkg;

    localparam logic [1:0] FUNC_ARRIVAL = 2'd0;
    localparam logic [1:0] FUNC_TAKE    = 2'd1;
    localparam logic [1:0] FUNC_DONE    = 2'd2;

    typedef enum logic [2:0] {
        ST_QUEUED       = 3'd0,
        ST_DROPPED      = 3'd1,
        ST_DISPATCHED   = 3'd2,
        ST_NOTHING      = 3'd3,
        ST_TURN_PASSED  = 3'd4,
        ST_DONE_IGNORED = 3'd5
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  server_index;
        logic [1:0]  turn_after;
        logic [6:0]  level_after;
    } result_t;

endpackage

// ===== rtl/core/tbqd_store.sv =====
// Handle memory: one write port and one registered read port.
`timescale 1ns / 1ps

module tbqd_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tbqd_ctrl.sv =====
// Queue pointers, counts, turn and busy flag, with the per-beat decision logic.
`timescale 1ns / 1ps

module tbqd_ctrl #(
    parameter int NUM_SERVERS = 4,
    parameter int QUEUE_DEPTH = 64,
    parameter int SW          = 16,
    parameter int AW          = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  logic [15:0]       conn_handle,
    output logic              busy,
    output logic              done,
    output tbqd_pkg::result_t result,
    output logic              dispatched,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [SW-1:0]     mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr
);

    import tbqd_pkg::*;

    localparam int TW = $clog2(NUM_SERVERS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   head_reg [NUM_SERVERS];
    logic [PW-1:0]   head_next [NUM_SERVERS];
    logic [PW-1:0]   tail_reg [NUM_SERVERS];
    logic [PW-1:0]   tail_next [NUM_SERVERS];
    logic [CW-1:0]   cnt_reg [NUM_SERVERS];
    logic [CW-1:0]   cnt_next [NUM_SERVERS];
    logic [TW-1:0]   turn_reg, turn_next;
    logic            srv_busy_reg, srv_busy_next;
    result_t         result_reg, result_next;
    logic            disp_reg, disp_next;

    logic            accept;
    logic [CW-1:0]   cur_cnt;
    logic [PW-1:0]   cur_head;
    logic [PW-1:0]   cur_tail;
    logic [AW-1:0]   base_addr;
    logic [CW-1:0]   new_cnt;
    logic [TW-1:0]   new_turn;
    status_t         new_status;

    assign accept    = start && (state_reg == S_IDLE);
    assign cur_cnt   = cnt_reg[turn_reg];
    assign cur_head  = head_reg[turn_reg];
    assign cur_tail  = tail_reg[turn_reg];
    assign base_addr = AW'(turn_reg) * AW'(QUEUE_DEPTH);

    assign mem_waddr = base_addr + AW'(cur_tail);
    assign mem_raddr = base_addr + AW'(cur_head);
    assign mem_wdata = conn_handle[SW-1:0];

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        cnt_next      = cnt_reg;
        turn_next     = turn_reg;
        srv_busy_next = srv_busy_reg;
        state_next    = state_reg;
        result_next   = result_reg;
        disp_next     = disp_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        new_cnt       = cur_cnt;
        new_turn      = turn_reg;
        new_status    = ST_DONE_IGNORED;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                    case (func)
                        FUNC_ARRIVAL:
                        begin
                            if (cur_cnt >= CW'(QUEUE_DEPTH))
                            begin
                                new_status = ST_DROPPED;
                            end
                            else
                            begin
                                mem_we              = 1'b1;
                                tail_next[turn_reg] = (cur_tail == PW'(QUEUE_DEPTH - 1)) ?
                                                      '0 : cur_tail + PW'(1);
                                new_cnt             = cur_cnt + CW'(1);
                                new_status          = ST_QUEUED;
                            end
                        end
                        FUNC_TAKE:
                        begin
                            if (srv_busy_reg || (cur_cnt == '0))
                            begin
                                new_status = ST_NOTHING;
                            end
                            else
                            begin
                                mem_re              = 1'b1;
                                head_next[turn_reg] = (cur_head == PW'(QUEUE_DEPTH - 1)) ?
                                                      '0 : cur_head + PW'(1);
                                new_cnt             = cur_cnt - CW'(1);
                                srv_busy_next       = 1'b1;
                                new_status          = ST_DISPATCHED;
                            end
                        end
                        FUNC_DONE:
                        begin
                            if (srv_busy_reg)
                            begin
                                srv_busy_next = 1'b0;
                                new_turn      = (turn_reg == TW'(NUM_SERVERS - 1)) ?
                                                '0 : turn_reg + TW'(1);
                                new_status    = ST_TURN_PASSED;
                            end
                            else
                            begin
                                new_status = ST_DONE_IGNORED;
                            end
                        end
                        default:
                        begin
                            new_status = ST_DONE_IGNORED;
                        end
                    endcase
                    cnt_next[turn_reg] = new_cnt;
                    turn_next          = new_turn;
                    disp_next          = (new_status == ST_DISPATCHED);
                    result_next        = '{status:       new_status,
                                           server_index: 2'(turn_reg),
                                           turn_after:   2'(new_turn),
                                           level_after:  7'(new_cnt)};
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            turn_reg     <= '0;
            srv_busy_reg <= 1'b0;
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            turn_reg     <= turn_next;
            srv_busy_reg <= srv_busy_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            cnt_reg      <= cnt_next;
        end
    end

    // The result fields are payload and carry no reset; done qualifies them.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        disp_reg   <= disp_next;
    end

    assign busy       = (state_reg == S_RESP);
    assign done       = (state_reg == S_RESP);
    assign result     = result_reg;
    assign dispatched = disp_reg;

endmodule

// ===== rtl/core/turn_based_queue_dispatcher_top.sv =====
// Top level of the turn-based queue dispatcher.
`timescale 1ns / 1ps

// Each command is accepted at a clock edge where start is high and busy is low,
// and its result beat appears in the next cycle with done high for exactly that
// one cycle, during which busy is high. The handle memory that holds all queues
// has a registered read port, and a dispatched handle is read into that beat.
// The receiver cannot stall; a result must be captured in its done cycle.

module turn_based_queue_dispatcher_top #(
    parameter int NUM_SERVERS  = 4,
    parameter int QUEUE_DEPTH  = 64,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  func,
    input  logic [15:0] conn_handle,
    output logic        busy,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] out_handle,
    output logic [1:0]  server_index,
    output logic [1:0]  turn_after,
    output logic [6:0]  level_after
);

    import tbqd_pkg::*;

    localparam int SW    = (HANDLE_WIDTH < 16) ? HANDLE_WIDTH : 16;
    localparam int DEPTH = NUM_SERVERS * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    result_t        result;
    logic           dispatched;
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_waddr;
    logic [AW-1:0]  mem_raddr;
    logic [SW-1:0]  mem_wdata;
    logic [SW-1:0]  mem_rdata;

    tbqd_ctrl #(
        .NUM_SERVERS (NUM_SERVERS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SW          (SW),
        .AW          (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .func        (func),
        .conn_handle (conn_handle),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .dispatched  (dispatched),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr)
    );

    tbqd_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign status       = result.status;
    assign out_handle   = dispatched ? 16'(mem_rdata) : 16'd0;
    assign server_index = result.server_index;
    assign turn_after   = result.turn_after;
    assign level_after  = result.level_after;

endmodule

// ===== rtl/core/tbqd_checker.sv =====
// Port-level checker for the dispatcher, bound to the top level.
`timescale 1ns / 1ps

module tbqd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [2:0]  status,
    input  logic [15:0] out_handle,
    input  logic [1:0]  server_index,
    input  logic [1:0]  turn_after
);

    import tbqd_pkg::*;

    // Every accepted command yields its result beat in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("accepted command produced no result beat");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat lasted more than one cycle");

    a_busy_only_resp: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> done)
        else $error("busy without a pending result beat");

    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != 3'(ST_DISPATCHED)) |-> out_handle == 16'd0)
        else $error("nonzero handle on a beat that dispatched nothing");

    a_turn_kept: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != 3'(ST_TURN_PASSED)) |-> turn_after == server_index)
        else $error("turn moved without a turn pass");

endmodule

bind turn_based_queue_dispatcher_top tbqd_checker u_tbqd_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the turn-based queue dispatcher.
`timescale 1ns / 1ps

module testbench;
    import tbqd_pkg::*;

    localparam int          NUM_SERVERS = 4;
    localparam int          QUEUE_DEPTH = 64;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          STALL_LIMIT = 1000;
    localparam int          DRAIN_CYCLES = 4;

    typedef struct {
        status_t     status;
        logic [15:0] out_handle;
        logic [1:0]  server_index;
        logic [1:0]  turn_after;
        logic [6:0]  level_after;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  func = FUNC_ARRIVAL;
    logic [15:0] conn_handle = '0;
    logic        busy;
    logic        done;
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [1:0]  server_index;
    logic [1:0]  turn_after;
    logic [6:0]  level_after;

    // Predicted dispatcher state.
    logic [15:0] handle_mem [NUM_SERVERS][QUEUE_DEPTH];
    int          rd_ptr [NUM_SERVERS];
    int          wr_ptr [NUM_SERVERS];
    int          fill [NUM_SERVERS];
    int          turn_q;
    bit          serving;

    outcome_t    pending_outcomes [$];
    int          mismatches = 0;
    int          commands_sent = 0;
    int          counted_commands = 0;
    int          beats_checked = 0;
    int          status_seen [8];
    int          sender_idle_pct = 0;
    int          stalled_cycles = 0;

    turn_based_queue_dispatcher_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .conn_handle  (conn_handle),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .out_handle   (out_handle),
        .server_index (server_index),
        .turn_after   (turn_after),
        .level_after  (level_after)
    );

    always #6 clk = ~clk;

    function automatic outcome_t dispatch_outcome(logic [1:0] f, logic [15:0] h);
        outcome_t o;
        int       srv;
        srv = turn_q;
        o.out_handle = '0;
        o.server_index = srv[1:0];
        case (f)
            FUNC_ARRIVAL:
            begin
                if (fill[srv] >= QUEUE_DEPTH)
                begin
                    o.status = ST_DROPPED;
                end
                else
                begin
                    handle_mem[srv][wr_ptr[srv]] = h;
                    wr_ptr[srv] = (wr_ptr[srv] + 1) % QUEUE_DEPTH;
                    fill[srv]++;
                    o.status = ST_QUEUED;
                end
            end
            FUNC_TAKE:
            begin
                if (serving || fill[srv] == 0)
                begin
                    o.status = ST_NOTHING;
                end
                else
                begin
                    o.out_handle = handle_mem[srv][rd_ptr[srv]];
                    rd_ptr[srv] = (rd_ptr[srv] + 1) % QUEUE_DEPTH;
                    fill[srv]--;
                    serving = 1'b1;
                    o.status = ST_DISPATCHED;
                end
            end
            FUNC_DONE:
            begin
                if (serving)
                begin
                    serving = 1'b0;
                    turn_q = (srv + 1) % NUM_SERVERS;
                    o.status = ST_TURN_PASSED;
                end
                else
                begin
                    o.status = ST_DONE_IGNORED;
                end
            end
            default:
            begin
                o.status = ST_DONE_IGNORED;
            end
        endcase
        o.turn_after = turn_q[1:0];
        o.level_after = fill[srv][6:0];
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Sends one command beat; start stays high on return so a following
    // command can be driven in the same step without a glitch. The sender
    // decides afresh in every cycle whether to hold start low.
    task automatic send_command(logic [1:0] f, logic [15:0] h);
        outcome_t o;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        conn_handle <= h;
        do @(posedge clk); while (busy !== 1'b0);
        o = dispatch_outcome(f, h);
        pending_outcomes.push_back(o);
        commands_sent++;
        if (o.status != ST_DONE_IGNORED)
            counted_commands++;
    endtask

    task automatic send_arrival();
        send_command(FUNC_ARRIVAL, 16'($urandom_range(0, 65535)));
    endtask

    task automatic send_op(logic [1:0] f);
        send_command(f, 16'($urandom_range(0, 65535)));
    endtask

    // Commands that must leave the state alone, starting from reset.
    task automatic test_idle_commands();
        send_op(FUNC_TAKE);
        send_op(FUNC_DONE);
        send_command(FUNC_UNUSED, 16'hFFFF);
        send_command(FUNC_UNUSED, 16'h0000);
    endtask

    // One full trip of the turn around all servers, with extreme handles,
    // takes while busy and arrivals while busy along the way.
    task automatic test_turn_rotation();
        send_command(FUNC_ARRIVAL, 16'h0000);
        send_command(FUNC_ARRIVAL, 16'hFFFF);
        send_command(FUNC_ARRIVAL, 16'hAAAA);
        send_op(FUNC_TAKE);
        send_op(FUNC_TAKE);
        send_command(FUNC_ARRIVAL, 16'h5555);
        send_op(FUNC_DONE);
        send_op(FUNC_DONE);
        send_op(FUNC_TAKE);
        send_command(FUNC_ARRIVAL, 16'h1234);
        send_op(FUNC_TAKE);
        send_op(FUNC_DONE);
        send_command(FUNC_ARRIVAL, 16'h8001);
        send_op(FUNC_TAKE);
        send_op(FUNC_DONE);
        send_command(FUNC_ARRIVAL, 16'h7FFE);
        send_op(FUNC_TAKE);
        send_op(FUNC_DONE);
    endtask

    // Mostly arrival/take/done sequences with random handles, some bursts
    // that overfill the turn holder's queue, and random noise commands.
    task automatic test_random_traffic(int n_commands, int idle_pct);
        int goal;
        int pick;
        int burst;
        goal = counted_commands + n_commands;
        sender_idle_pct = idle_pct;
        while (counted_commands < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 68)
            begin
                repeat ($urandom_range(0, 2)) send_arrival();
                send_op(FUNC_TAKE);
                if ($urandom_range(3) == 0)
                    send_arrival();
                if ($urandom_range(4) == 0)
                    send_op(FUNC_TAKE);
                send_op(FUNC_DONE);
            end
            else if (pick < 70)
            begin
                burst = QUEUE_DEPTH - fill[turn_q] + $urandom_range(1, 3);
                repeat (burst) send_arrival();
            end
            else
            begin
                send_op(2'($urandom_range(0, 3)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result beat with no command outstanding");
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("status", 16'(status), 16'(want.status));
                check_field("out_handle", out_handle, want.out_handle);
                check_field("server_index", 16'(server_index), 16'(want.server_index));
                check_field("turn_after", 16'(turn_after), 16'(want.turn_after));
                check_field("level_after", 16'(level_after), 16'(want.level_after));
                status_seen[want.status]++;
                beats_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (stalled_cycles < STALL_LIMIT) @(posedge clk);
        $display("FAIL turn_based_queue_dispatcher_top");
        $finish;
    end

    initial
    begin
        for (int s = 0; s < NUM_SERVERS; s++)
        begin
            rd_ptr[s] = 0;
            wr_ptr[s] = 0;
            fill[s] = 0;
        end
        turn_q = 0;
        serving = 1'b0;
        foreach (status_seen[i]) status_seen[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_commands();
        test_turn_rotation();
        test_random_traffic(250, 21);
        test_random_traffic(250, 83);
        test_random_traffic(250, 0);
        start <= 1'b0;

        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands over three sender pacings; checked %0d result beats.",
                 commands_sent, beats_checked);
        $display(
            "Outcomes: queued %0d, dropped %0d, dispatched %0d, none %0d, passed %0d, ignored %0d.",
            status_seen[ST_QUEUED], status_seen[ST_DROPPED], status_seen[ST_DISPATCHED],
            status_seen[ST_NOTHING], status_seen[ST_TURN_PASSED],
            status_seen[ST_DONE_IGNORED]);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("PASS turn_based_queue_dispatcher_top");
        else
            $display("FAIL turn_based_queue_dispatcher_top");
        $finish;
    end

endmodule
